FILE: hdl/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define TBCK_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tbck: same-cycle check failed");

// Next-cycle implication, off during reset.
`define TBCK_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tbck: next-cycle check failed");

// Holds in the cycle after reset is seen.
`define TBCK_ASSERT_RST(label, cons) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("tbck: post-reset check failed");

`endif

FILE: hdl/tbck_pkg.sv
// Package: widths, register indexes, stage grouping and carried types of the CM kinematics pipe.
`timescale 1ns / 1ps
package tbck_pkg;
    localparam int E_W       = 32;   // energy / mass / momentum word
    localparam int SQ_W      = 64;   // squared quantity word
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROJ_MASS_SQ     = 3'd0,
        CFG_TARGET_MASS_SQ   = 3'd1,
        CFG_TARGET_MASS      = 3'd2,
        CFG_EJECTILE_MASS_SQ = 3'd3,
        CFG_RESIDUE_MASS_SQ  = 3'd4,
        CFG_RESIDUE_MASS     = 3'd5
    } t_cfg_idx;

    localparam int SQRT_STEPS   = E_W;   // one root bit per step
    localparam int SQRT_PER_STG = 2;
    localparam int DIV_STEPS    = SQ_W;  // one quotient bit per step
    localparam int DIV_PER_STG  = 2;

    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

    // carried alongside the first root
    typedef struct packed {
        logic [SQ_W-1:0] s;
        logic            ov;
        logic            deg;
        logic            neg;
        logic [SQ_W:0]   mag;
    } t_sq1_side;

    // carried through the divider
    typedef struct packed {
        logic [SQ_W-1:0] s;
        logic            ov;
        logic            deg;
        logic            neg;
        logic [E_W-1:0]  root;
    } t_div_side;

    // carried alongside the momentum root
    typedef struct packed {
        logic [SQ_W-1:0] s;
        logic [E_W-1:0]  ec;
        logic [E_W-1:0]  ed;
        logic            ov;
        logic            deg;
    } t_sq2_side;
endpackage

FILE: hdl/tbck_isqrt.sv
// Pipelined floor square root of a 64-bit word, a fixed number of root bits per stage.
`timescale 1ns / 1ps
module tbck_isqrt #(
    parameter int PER_STG = tbck_pkg::SQRT_PER_STG,
    parameter int SIDE_W  = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tbck_pkg::t_pipe_ctl       i_ctl,
    input  logic [tbck_pkg::SQ_W-1:0] i_x,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_valid,
    output logic [tbck_pkg::E_W-1:0]  o_root,
    output logic [SIDE_W-1:0]         o_side
);
    import tbck_pkg::*;

    localparam int NSTG  = SQRT_STEPS / PER_STG;
    localparam int REM_W = E_W + 2;
    localparam int TMP_W = REM_W + 2;

    logic              r_v    [NSTG];
    logic [SQ_W-1:0]   r_x    [NSTG];
    logic [E_W-1:0]    r_q    [NSTG];
    logic [REM_W-1:0]  r_rem  [NSTG];
    logic [SIDE_W-1:0] r_side [NSTG];

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        logic              v_in;
        logic [SQ_W-1:0]   x_in, n_x;
        logic [E_W-1:0]    q_in, n_q;
        logic [REM_W-1:0]  rem_in, n_rem;
        logic [SIDE_W-1:0] side_in;
        logic [TMP_W-1:0]  acc, trial;

        if (g == 0) begin : g_first
            assign v_in    = i_ctl.valid;
            assign x_in    = i_x;
            assign q_in    = '0;
            assign rem_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[g-1];
            assign x_in    = r_x[g-1];
            assign q_in    = r_q[g-1];
            assign rem_in  = r_rem[g-1];
            assign side_in = r_side[g-1];
        end

        // restoring digit recurrence, two input bits per root bit
        always_comb begin
            n_x   = x_in;
            n_q   = q_in;
            n_rem = rem_in;
            acc   = '0;
            trial = '0;
            for (int k = 0; k < PER_STG; k++) begin
                acc   = {n_rem, n_x[SQ_W-1 -: 2]};
                trial = {2'b00, n_q, 2'b01};
                if (acc >= trial) begin
                    n_rem = REM_W'(acc - trial);
                    n_q   = {n_q[E_W-2:0], 1'b1};
                end else begin
                    n_rem = REM_W'(acc);
                    n_q   = {n_q[E_W-2:0], 1'b0};
                end
                n_x = {n_x[SQ_W-3:0], 2'b00};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_x[g]    <= n_x;
                r_q[g]    <= n_q;
                r_rem[g]  <= n_rem;
                r_side[g] <= side_in;
            end
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_root  = r_q[NSTG-1];
    assign o_side  = r_side[NSTG-1];
endmodule

FILE: hdl/two_body_cm_kinematics.sv
// Top level: two-body CM kinematics pipe, s -> sqrt(s) -> Ec -> pc and Ed.
// Registered stages in order: A, B, C, the sqrt(s) pipe, the divider, E, F, G,
//   the momentum sqrt pipe and the output register.
// Throughput: one word per cycle; the whole pipe holds while a result word waits.
// Reset (synchronous, active low) clears valid bits and zeroes the six mass registers.
`timescale 1ns / 1ps
module two_body_cm_kinematics #(
    parameter int SQRT_PER_STG = tbck_pkg::SQRT_PER_STG,
    parameter int DIV_PER_STG  = tbck_pkg::DIV_PER_STG
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tbck_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tbck_pkg::SQ_W-1:0]      i_cfg_data,
    // input word channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tbck_pkg::E_W-1:0]       i_proj_energy,
    // result word channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tbck_pkg::SQ_W-1:0]      o_mandelstam_s,
    output logic signed [tbck_pkg::E_W-1:0] o_ejectile_cm_energy,
    output logic [tbck_pkg::E_W-1:0]       o_ejectile_cm_momentum,
    output logic [tbck_pkg::E_W-1:0]       o_residue_cm_energy,
    output logic                           o_overflow,
    output logic                           o_degenerate
);
    import tbck_pkg::*;

    localparam int ND    = DIV_STEPS / DIV_PER_STG;
    localparam int DR_W  = E_W + 1;     // divisor 2*root, remainder below it
    localparam int DT_W  = DR_W + 1;
    localparam int DS_W  = E_W + 3;     // signed root - Ec

    // ---------------- configuration registers ----------------
    logic [SQ_W-1:0] r_proj_mass_sq, r_target_mass_sq, r_ejectile_mass_sq, r_residue_mass_sq;
    logic [E_W-1:0]  r_target_mass, r_residue_mass;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proj_mass_sq     <= '0;
            r_target_mass_sq   <= '0;
            r_target_mass      <= '0;
            r_ejectile_mass_sq <= '0;
            r_residue_mass_sq  <= '0;
            r_residue_mass     <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PROJ_MASS_SQ:     r_proj_mass_sq     <= i_cfg_data;
                CFG_TARGET_MASS_SQ:   r_target_mass_sq   <= i_cfg_data;
                CFG_TARGET_MASS:      r_target_mass      <= i_cfg_data[E_W-1:0];
                CFG_EJECTILE_MASS_SQ: r_ejectile_mass_sq <= i_cfg_data;
                CFG_RESIDUE_MASS_SQ:  r_residue_mass_sq  <= i_cfg_data;
                CFG_RESIDUE_MASS:     r_residue_mass     <= i_cfg_data[E_W-1:0];
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    // ---------------- global advance ----------------
    // Every stage moves together; only a result word that is held freezes the pipe.
    logic      r_out_valid;
    logic      en;
    t_pipe_ctl sq1_ctl, sq2_ctl;

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_out_valid && i_out_stall;

    // ---------------- stage A: mb*Ea and ma^2 + mb^2 ----------------
    logic            r_a_v, r_a_ov;
    logic [SQ_W-1:0] r_a_prod, r_a_s1;
    logic [SQ_W:0]   a_sum;

    assign a_sum = {1'b0, r_proj_mass_sq} + {1'b0, r_target_mass_sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_prod <= SQ_W'(r_target_mass) * SQ_W'(i_proj_energy);
            r_a_s1   <= a_sum[SQ_W] ? '1 : a_sum[SQ_W-1:0];
            r_a_ov   <= a_sum[SQ_W];
        end
    end

    // ---------------- stage B: s, saturating ----------------
    logic            r_b_v, r_b_ov;
    logic [SQ_W-1:0] r_b_s, b_twice;
    logic [SQ_W:0]   b_sum;

    assign b_twice = r_a_prod[SQ_W-1] ? '1 : {r_a_prod[SQ_W-2:0], 1'b0};
    assign b_sum   = {1'b0, r_a_s1} + {1'b0, b_twice};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_s  <= b_sum[SQ_W] ? '1 : b_sum[SQ_W-1:0];
            r_b_ov <= r_a_ov | r_a_prod[SQ_W-1] | b_sum[SQ_W];
        end
    end

    // ---------------- stage C: numerator s + mc^2 - md^2 as sign/magnitude ----------------
    logic          r_c_v;
    t_sq1_side     r_c_side;
    logic [SQ_W:0] c_alo, c_md2;

    assign c_alo = {1'b0, r_b_s} + {1'b0, r_ejectile_mass_sq};
    assign c_md2 = {1'b0, r_residue_mass_sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_side.s   <= r_b_s;
            r_c_side.ov  <= r_b_ov;
            r_c_side.deg <= (r_b_s == '0);
            r_c_side.neg <= (c_alo < c_md2);
            r_c_side.mag <= (c_alo < c_md2) ? (c_md2 - c_alo) : (c_alo - c_md2);
        end
    end

    // ---------------- sqrt(s) ----------------
    logic           sq1_v;
    logic [E_W-1:0] sq1_root;
    t_sq1_side      sq1_side;

    assign sq1_ctl = '{en: en, valid: r_c_v};

    tbck_isqrt #(
        .PER_STG (SQRT_PER_STG),
        .SIDE_W  ($bits(t_sq1_side))
    ) u_sqrt_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sq1_ctl),
        .i_x     (r_c_side.s),
        .i_side  (r_c_side),
        .o_valid (sq1_v),
        .o_root  (sq1_root),
        .o_side  (sq1_side)
    );

    // ---------------- divider: |numerator| / (2*root), restoring ----------------
    logic            r_dv_v    [ND];
    logic [DR_W-1:0] r_dv_rem  [ND];
    logic [SQ_W-1:0] r_dv_lo   [ND];
    logic [SQ_W-1:0] r_dv_q    [ND];
    t_div_side       r_dv_side [ND];

    for (genvar g = 0; g < ND; g++) begin : g_div
        logic            v_in;
        logic [DR_W-1:0] rem_in, n_rem;
        logic [SQ_W-1:0] lo_in, n_lo, q_in, n_q;
        t_div_side       side_in;
        logic [DT_W-1:0] acc, dd;

        if (g == 0) begin : g_first
            assign v_in         = sq1_v;
            assign rem_in       = DR_W'(sq1_side.mag[SQ_W]);
            assign lo_in        = sq1_side.mag[SQ_W-1:0];
            assign q_in         = '0;
            assign side_in.s    = sq1_side.s;
            assign side_in.ov   = sq1_side.ov;
            assign side_in.deg  = sq1_side.deg;
            assign side_in.neg  = sq1_side.neg;
            assign side_in.root = sq1_root;
        end else begin : g_next
            assign v_in    = r_dv_v[g-1];
            assign rem_in  = r_dv_rem[g-1];
            assign lo_in   = r_dv_lo[g-1];
            assign q_in    = r_dv_q[g-1];
            assign side_in = r_dv_side[g-1];
        end

        assign dd = {1'b0, side_in.root, 1'b0};

        always_comb begin
            n_rem = rem_in;
            n_lo  = lo_in;
            n_q   = q_in;
            acc   = '0;
            for (int k = 0; k < DIV_PER_STG; k++) begin
                acc = {n_rem, n_lo[SQ_W-1]};
                if (acc >= dd) begin
                    n_rem = DR_W'(acc - dd);
                    n_q   = {n_q[SQ_W-2:0], 1'b1};
                end else begin
                    n_rem = DR_W'(acc);
                    n_q   = {n_q[SQ_W-2:0], 1'b0};
                end
                n_lo = {n_lo[SQ_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[g] <= 1'b0;
            end else if (en) begin
                r_dv_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem[g]  <= n_rem;
                r_dv_lo[g]   <= n_lo;
                r_dv_q[g]    <= n_q;
                r_dv_side[g] <= side_in;
            end
        end
    end

    // ---------------- stage E: signed Ec with saturation ----------------
    logic            r_e_v, r_e_ov;
    logic [E_W-1:0]  r_e_ec;
    t_div_side       r_e_side;
    t_div_side       e_in;
    logic [SQ_W-1:0] e_q;
    logic            e_sat;
    logic [E_W-1:0]  e_ec;

    assign e_in = r_dv_side[ND-1];
    assign e_q  = r_dv_q[ND-1];

    always_comb begin
        if (!e_in.neg) begin
            e_sat = (e_q > SQ_W'(32'h7FFF_FFFF));
            e_ec  = e_sat ? 32'h7FFF_FFFF : e_q[E_W-1:0];
        end else begin
            e_sat = (e_q > SQ_W'(32'h8000_0000));
            e_ec  = e_sat ? 32'h8000_0000 : (~e_q[E_W-1:0] + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (en) begin
            r_e_v <= r_dv_v[ND-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_ec   <= e_ec;
            r_e_ov   <= e_in.ov | (e_sat & !e_in.deg);
            r_e_side <= e_in;
        end
    end

    // ---------------- stage F: Ec^2 and Ed = max(root - Ec, md) ----------------
    logic            r_f_v;
    logic [SQ_W-1:0] r_f_sq;
    t_sq2_side       r_f_side;
    logic [E_W-1:0]  f_abs;
    logic [DS_W-1:0] f_d, f_dc;
    logic            f_sat;

    assign f_abs = r_e_ec[E_W-1] ? (~r_e_ec + 1'b1) : r_e_ec;
    assign f_d   = {3'b000, r_e_side.root} - {{3{r_e_ec[E_W-1]}}, r_e_ec};
    assign f_dc  = ($signed(f_d) < $signed({3'b000, r_residue_mass}))
                   ? {3'b000, r_residue_mass} : f_d;
    assign f_sat = ($signed(f_dc) > $signed({3'b000, {E_W{1'b1}}}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (en) begin
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_sq       <= SQ_W'(f_abs) * SQ_W'(f_abs);
            r_f_side.s   <= r_e_side.s;
            r_f_side.ec  <= r_e_ec;
            r_f_side.ed  <= f_sat ? '1 : f_dc[E_W-1:0];
            r_f_side.ov  <= r_e_ov | (f_sat & !r_e_side.deg);
            r_f_side.deg <= r_e_side.deg;
        end
    end

    // ---------------- stage G: momentum argument, zero below threshold ----------------
    logic            r_g_v;
    logic [SQ_W-1:0] r_g_arg;
    t_sq2_side       r_g_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (en) begin
            r_g_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_arg  <= (r_f_sq > r_ejectile_mass_sq) ? (r_f_sq - r_ejectile_mass_sq) : '0;
            r_g_side <= r_f_side;
        end
    end

    // ---------------- pc = sqrt(Ec^2 - mc^2) ----------------
    logic           sq2_v;
    logic [E_W-1:0] sq2_root;
    t_sq2_side      sq2_side;

    assign sq2_ctl = '{en: en, valid: r_g_v};

    tbck_isqrt #(
        .PER_STG (SQRT_PER_STG),
        .SIDE_W  ($bits(t_sq2_side))
    ) u_sqrt_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sq2_ctl),
        .i_x     (r_g_arg),
        .i_side  (r_g_side),
        .o_valid (sq2_v),
        .o_root  (sq2_root),
        .o_side  (sq2_side)
    );

    // ---------------- output register ----------------
    // Zero s: energies and momentum forced, residue energy takes its floor.
    logic [SQ_W-1:0] r_out_s;
    logic [E_W-1:0]  r_out_ec, r_out_pc, r_out_ed;
    logic            r_out_ov, r_out_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= sq2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_s   <= sq2_side.s;
            r_out_ec  <= sq2_side.deg ? '0 : sq2_side.ec;
            r_out_pc  <= sq2_side.deg ? '0 : sq2_root;
            r_out_ed  <= sq2_side.deg ? r_residue_mass : sq2_side.ed;
            r_out_ov  <= sq2_side.ov;
            r_out_deg <= sq2_side.deg;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_mandelstam_s         = r_out_s;
    assign o_ejectile_cm_energy   = r_out_ec;
    assign o_ejectile_cm_momentum = r_out_pc;
    assign o_residue_cm_energy    = r_out_ed;
    assign o_overflow             = r_out_ov;
    assign o_degenerate           = r_out_deg;
endmodule

FILE: hdl/tbck_checker.sv
// Port-level checker for the CM kinematics pipe, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tbck_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [tbck_pkg::SQ_W-1:0]      o_mandelstam_s,
    input logic signed [tbck_pkg::E_W-1:0] o_ejectile_cm_energy,
    input logic [tbck_pkg::E_W-1:0]       o_ejectile_cm_momentum,
    input logic                           o_degenerate
);
    `TBCK_ASSERT_RST(a_reset_clears_out, !o_out_valid)
    `TBCK_ASSERT_IMP(a_stall_from_held_word, 1'b1, o_in_stall == (o_out_valid && i_out_stall))
    `TBCK_ASSERT_NXT(a_held_word_stays, o_out_valid && i_out_stall, o_out_valid && $stable(o_mandelstam_s))
    `TBCK_ASSERT_IMP(a_degenerate_zeros, o_out_valid && o_degenerate, o_mandelstam_s == 64'd0 && o_ejectile_cm_energy == 32'sd0 && o_ejectile_cm_momentum == 32'd0)
endmodule

bind two_body_cm_kinematics tbck_checker u_tbck_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .o_in_stall             (o_in_stall),
    .o_out_valid            (o_out_valid),
    .i_out_stall            (i_out_stall),
    .o_mandelstam_s         (o_mandelstam_s),
    .o_ejectile_cm_energy   (o_ejectile_cm_energy),
    .o_ejectile_cm_momentum (o_ejectile_cm_momentum),
    .o_degenerate           (o_degenerate)
);

FILE: dv/two_body_cm_kinematics_test.sv
// Testbench for the two-body CM kinematics pipe: directed table, random words, self-check.
`timescale 1ns / 1ps
module two_body_cm_kinematics_test;
    import tbck_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;  // unmapped, write is dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam int DRAIN_CYCLES = 90;                   // a margin over the depth of the pipe
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] s;
        logic [31:0] ec;
        logic [31:0] pc;
        logic [31:0] ed;
        logic        ov;
        logic        deg;
    } kin_t;

    // directed stimulus: energy, and a typed-in result where it is obvious
    typedef struct packed {
        logic [31:0] energy;
        logic        known;
        kin_t        res;
    } row_t;

    logic i_clk, i_rst_n;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0] i_cfg_data;
    logic i_in_valid, o_in_stall;
    logic [31:0] i_proj_energy;
    logic o_out_valid, i_out_stall;
    logic [63:0] o_mandelstam_s;
    logic signed [31:0] o_ejectile_cm_energy;
    logic [31:0] o_ejectile_cm_momentum, o_residue_cm_energy;
    logic o_overflow, o_degenerate;

    two_body_cm_kinematics DUT (.*);

    // local copy of the six mass registers
    logic [63:0] ma2, mb2, mc2, md2;
    logic [31:0] mb, md;

    kin_t expected_q[$];
    int   mismatches, words_in, words_out, cfg_writes;
    int   cycles;
    bit   send_idle, recv_idle;   // random idling on/off per side
    int   hold_cycles;            // receiver long hold-off request

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     expected_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] floor_sqrt(logic [63:0] x);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (32'd1 << i);
            if ({32'd0, t} * {32'd0, t} <= x) r = t;
        end
        return r;
    endfunction

    // s, sqrt(s), Ec, pc and Ed from the lab energy and the current masses
    function automatic kin_t cm_kinematics(logic [31:0] ea);
        kin_t k;
        logic [63:0] prod, twice, root64, a, sq;
        logic [64:0] sum, num, mag, quo;
        logic [31:0] root;
        longint ec, d;
        k = '0;
        prod = {32'd0, mb} * {32'd0, ea};
        if (prod[63]) begin
            k.ov = 1'b1;
            twice = MAX64;
        end else begin
            twice = prod << 1;
        end
        sum = {1'b0, ma2} + {1'b0, mb2};
        if (sum[64]) begin
            k.ov = 1'b1;
            sum = {1'b0, MAX64};
        end
        sum = sum + {1'b0, twice};
        if (sum[64]) begin
            k.ov = 1'b1;
            sum = {1'b0, MAX64};
        end
        k.s = sum[63:0];
        if (k.s == 0) begin
            k.deg = 1'b1;
            k.ed = md;
            return k;
        end
        root = floor_sqrt(k.s);
        root64 = {32'd0, root};
        num = {1'b0, k.s} + {1'b0, mc2};
        if (num >= {1'b0, md2}) mag = num - {1'b0, md2};
        else mag = {1'b0, md2} - num;
        quo = mag / {root64[63:0], 1'b0};
        if (num >= {1'b0, md2}) begin
            if (quo > 65'h7FFF_FFFF) begin
                k.ov = 1'b1;
                quo = 65'h7FFF_FFFF;
            end
            ec = longint'(quo[63:0]);
        end else begin
            if (quo > 65'h8000_0000) begin
                k.ov = 1'b1;
                quo = 65'h8000_0000;
            end
            ec = -longint'(quo[63:0]);
        end
        k.ec = ec[31:0];
        a = (ec < 0) ? -ec : ec;
        sq = a * a;
        k.pc = (sq > mc2) ? floor_sqrt(sq - mc2) : 32'd0;
        d = longint'(root64) - ec;
        if (d < longint'({32'd0, md})) d = longint'({32'd0, md});
        if (d > 64'sh0_FFFF_FFFF) begin
            k.ov = 1'b1;
            d = 64'sh0_FFFF_FFFF;
        end
        k.ed = d[31:0];
        return k;
    endfunction

    // result side: check accepted words, drive stall
    always @(posedge i_clk) begin
        kin_t got, want;
        if (o_out_valid && !i_out_stall) begin
            got = '{o_mandelstam_s, o_ejectile_cm_energy, o_ejectile_cm_momentum,
                    o_residue_cm_energy, o_overflow, o_degenerate};
            words_out <= words_out + 1;
            if (expected_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result word s=%h", got.s);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display({"mismatch: exp s=%h ec=%h pc=%h ed=%h ov=%b deg=%b",
                                  " | got s=%h ec=%h pc=%h ed=%h ov=%b deg=%b"},
                                 want.s, want.ec, want.pc, want.ed, want.ov, want.deg,
                                 got.s, got.ec, got.pc, got.ed, got.ov, got.deg);
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= recv_idle && ($urandom_range(99) < 20);
        end
    end

    // offer one word; valid stays high into the next call unless a gap is drawn
    task automatic send_energy(logic [31:0] e, bit known, kin_t res);
        while (send_idle && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_proj_energy <= e;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(known ? res : cm_kinematics(e));
        words_in++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_PROJ_MASS_SQ:     ma2 = val;
            CFG_TARGET_MASS_SQ:   mb2 = val;
            CFG_TARGET_MASS:      mb  = val[31:0];
            CFG_EJECTILE_MASS_SQ: mc2 = val;
            CFG_RESIDUE_MASS_SQ:  md2 = val;
            CFG_RESIDUE_MASS:     md  = val[31:0];
            default: ;
        endcase
    endtask

    task automatic set_masses(logic [63:0] a2, logic [63:0] b2, logic [31:0] b,
                              logic [63:0] c2, logic [63:0] d2, logic [31:0] d);
        write_reg(CFG_PROJ_MASS_SQ, a2);
        write_reg(CFG_TARGET_MASS_SQ, b2);
        write_reg(CFG_TARGET_MASS, {$urandom, b});  // upper bits must be dropped
        write_reg(CFG_EJECTILE_MASS_SQ, c2);
        write_reg(CFG_RESIDUE_MASS_SQ, d2);
        write_reg(CFG_RESIDUE_MASS, {$urandom, d});
    endtask

    // physical-looking masses: squares consistent with the masses
    task automatic physical_masses(int bits);
        logic [31:0] a, b, c, d;
        a = $urandom_range(0, (1 << bits) - 1);
        b = $urandom_range(1, (1 << bits) - 1);
        c = $urandom_range(0, (1 << bits) - 1);
        d = $urandom_range(0, (1 << bits) - 1);
        set_masses(a * a, b * b, b, c * c, d * d, d);
    endtask

    function automatic logic [31:0] rand_energy();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h000F_FFFF);
            2: return $urandom_range(0, 32'h0000_0FFF);
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    row_t table_rows[12];
    kin_t dead;

    initial begin
        i_rst_n = 1'b0; i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_proj_energy = '0; i_out_stall = 1'b0;
        ma2 = '0; mb2 = '0; mc2 = '0; md2 = '0; mb = '0; md = '0;
        mismatches = 0; words_in = 0; words_out = 0; cfg_writes = 0; cycles = 0;
        send_idle = 1'b1; recv_idle = 1'b1; hold_cycles = 0;

        // all masses zero after reset: s is zero whatever the energy
        dead = '{64'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1};
        table_rows[0]  = '{32'h0000_0000, 1'b1, dead};
        table_rows[1]  = '{32'hFFFF_FFFF, 1'b1, dead};
        table_rows[2]  = '{32'h8000_0000, 1'b1, dead};
        table_rows[3]  = '{32'h5555_5555, 1'b1, dead};
        table_rows[4]  = '{32'hAAAA_AAAA, 1'b1, dead};
        table_rows[5]  = '{32'h0000_0001, 1'b1, dead};
        // rows under the all-ones, residue-only and ejectile-maximum settings, predicted
        table_rows[6]  = '{32'h0000_0000, 1'b0, dead};
        table_rows[7]  = '{32'hFFFF_FFFF, 1'b0, dead};
        table_rows[8]  = '{32'h0000_0001, 1'b0, dead};
        table_rows[9]  = '{32'h0000_0100, 1'b0, dead};
        table_rows[10] = '{32'h0001_0000, 1'b0, dead};
        table_rows[11] = '{32'h8000_0000, 1'b0, dead};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 6; i++)
            send_energy(table_rows[i].energy, table_rows[i].known, table_rows[i].res);
        wait_idle();
        // every register at its maximum: s saturates
        set_masses(MAX64, MAX64, 32'hFFFF_FFFF, MAX64, MAX64, 32'hFFFF_FFFF);
        for (int i = 6; i < 12; i++) send_energy(table_rows[i].energy, 1'b0, dead);
        wait_idle();
        // residue terms and a unit projectile mass squared set: large negative Ec, residue floor
        set_masses(64'd1, 64'd0, 32'd0, 64'd0, MAX64, 32'h8000_0000);
        for (int i = 6; i < 12; i++) send_energy(table_rows[i].energy, 1'b0, dead);
        wait_idle();
        // ejectile mass squared at maximum: Ec saturates high
        set_masses(64'd0, 64'd1, 32'd1, MAX64, 64'd0, 32'd0);
        for (int i = 6; i < 12; i++) send_energy(table_rows[i].energy, 1'b0, dead);
        wait_idle();
        write_reg(CFG_SPARE_6, $urandom);
        write_reg(CFG_SPARE_7, {$urandom, $urandom});

        // random phases under varied settings
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            case (ph % 4)
                0: physical_masses(20);
                1: physical_masses(12);
                2: set_masses({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                              {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
                default: set_masses({$urandom, $urandom} >> $urandom_range(63),
                                    {$urandom, $urandom} >> $urandom_range(63),
                                    $urandom >> $urandom_range(31),
                                    {$urandom, $urandom} >> $urandom_range(63),
                                    {$urandom, $urandom} >> $urandom_range(63),
                                    $urandom >> $urandom_range(31));
            endcase
            if (ph == 2) begin
                // receiver holds off long while the sender keeps offering
                send_idle = 1'b0;
                hold_cycles = 300;
            end
            if (ph == 5) begin
                send_idle = 1'b0;  // back-to-back stretch, no idling either side
                recv_idle = 1'b0;
            end
            // the hold-off phase offers more words than the pipe holds
            for (int n = 0; n < ((ph == 2) ? 100 : 40); n++) begin
                send_energy(rand_energy(), 1'b0, dead);
                if (n == 20 && ph == 3) begin
                    // sender waits for the pipe to drain completely
                    i_in_valid <= 1'b0;
                    while (expected_q.size() != 0) @(posedge i_clk);
                end
            end
            send_idle = 1'b1;
            recv_idle = 1'b1;
        end

        wait_idle();
        $display("%0d words in, %0d results checked, %0d register writes, %0d mismatches",
                 words_in, words_out, cfg_writes, mismatches);
        $display("covered: zero-s, saturated s/Ec/Ed, residue floor, random and physical masses");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
